@@ hdl/prf_pkg.sv @@
// shared types and constants of the point region filter
`timescale 1ns / 1ps

package prf_pkg;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_EVAL,
    ST_OUT
  } state_t;

  localparam logic [2:0] TYPE_NONE     = 3'd0;
  localparam logic [2:0] TYPE_CUBE     = 3'd1;
  localparam logic [2:0] TYPE_BLOCK    = 3'd2;
  localparam logic [2:0] TYPE_SPHERE   = 3'd3;
  localparam logic [2:0] TYPE_CYLINDER = 3'd4;
  localparam logic [2:0] TYPE_CONE     = 3'd5;

  localparam int WORD_W = 4;
  localparam int WORDS_PER_FILTER = 16;
  localparam logic [WORD_W-1:0] WORD_TYPE = 4'd0;

  localparam int IN_TDATA_W  = 168;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_TUSER_W = 1;

  localparam int MUL_W  = 33;
  localparam int PROD_W = 66;
  localparam int ROW_W  = PROD_W - 28;

  // evaluation schedule of one filter
  localparam logic [4:0] STEP_ROT_LAST  = 5'd9;
  localparam logic [4:0] STEP_TRANS0    = 5'd10;
  localparam logic [4:0] STEP_TRANS2    = 5'd12;
  localparam logic [4:0] STEP_THR0      = 5'd13;
  localparam logic [4:0] STEP_THR2      = 5'd15;
  localparam logic [4:0] STEP_SQ0       = 5'd16;
  localparam logic [4:0] STEP_SQ1       = 5'd17;
  localparam logic [4:0] STEP_SQ2       = 5'd18;
  localparam logic [4:0] STEP_CONE_LO   = 5'd19;
  localparam logic [4:0] STEP_CONE_HI   = 5'd20;
  localparam logic [4:0] STEP_CONE_SUM  = 5'd21;
  localparam logic [4:0] STEP_DECIDE    = 5'd22;

endpackage

@@ hdl/point_region_filter.sv @@
// top level of the point region filter: sequencer, filter table and counters
`timescale 1ns / 1ps

// Classifies 3-D points against up to NUM_FILTERS region filters.
// The in_ channel carries either a table word write (in_tuser[0] = 1) or a
// point (in_tuser[0] = 0, in_tuser[1] clears all removal counters first).
// A table write is taken in the idle state and gives no result. A point gives one
// result on the out_ channel: keep flag in out_tuser, removing filter index
// and its updated saturating counter in out_tdata.
// Filters are scanned from the top index down; a filter of type none is skipped,
// any other is evaluated on the single shared multiplier
// (nine rotation products, three squares, two cone partial products).
// The scan stops early when a filter removes the point.
// The block takes one item at a time: in_tready is low from a point request
// until its result has been taken.
// A stalled receiver simply holds the result in the output register.
// After reset the filter table is swept to zero with in_tready low;
// filter types and counters clear at once.

module point_region_filter #(
  parameter int NUM_FILTERS = 8,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // coord_x, coord_y, coord_z, filter_slot, word_slot, word_value, pad
  input  logic [prf_pkg::IN_TDATA_W-1:0]      in_tdata,
  // kind, first_point
  input  logic [prf_pkg::IN_TUSER_W-1:0]      in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // removed_by, removal_count, pad
  output logic [prf_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // keep
  output logic [prf_pkg::OUT_TUSER_W-1:0]     out_tuser
);

  localparam int FIW   = (NUM_FILTERS > 1) ? $clog2(NUM_FILTERS) : 1;
  localparam int DEPTH = NUM_FILTERS * prf_pkg::WORDS_PER_FILTER;
  localparam int AW    = FIW + prf_pkg::WORD_W;

  // input fields
  logic                         kind, first_point;
  logic signed [31:0]           coord_x, coord_y, coord_z;
  logic [2:0]                   filter_slot;
  logic [prf_pkg::WORD_W-1:0]   word_slot;
  logic [63:0]                  word_value;

  assign kind        = in_tuser[0];
  assign first_point = in_tuser[1];
  assign coord_x     = in_tdata[31:0];
  assign coord_y     = in_tdata[63:32];
  assign coord_z     = in_tdata[95:64];
  assign filter_slot = in_tdata[98:96];
  assign word_slot   = in_tdata[102:99];
  assign word_value  = in_tdata[166:103];

  prf_pkg::state_t state_r, state_nxt;
  logic [FIW-1:0]  cur_r, cur_nxt;
  logic [4:0]      step_r, step_nxt;
  logic [AW-1:0]   clr_r;

  logic signed [31:0] px_r, py_r, pz_r;
  logic [3:0]         typ_r [NUM_FILTERS];

  logic [63:0]     tbl_mem [DEPTH];
  logic [63:0]     rd_r;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [63:0]     mem_wdata;

  logic [COUNT_WIDTH-1:0] cnt_mem [NUM_FILTERS];
  logic [COUNT_WIDTH-1:0] cnt_rd_r, cur_cnt, cnt_new;
  logic [NUM_FILTERS-1:0] cnt_vld_r;

  logic signed [prf_pkg::PROD_W-1:0] acc_r, sum_cur, prod_r;
  logic signed [prf_pkg::ROW_W-1:0]  rows_r [3];
  logic signed [31:0]                v_r [3];
  logic [63:0]                       thr_r [3];
  logic [63:0]                       sq_r [3];
  logic [63:0]                       pplo_r;
  logic [95:0]                       cone_r;

  logic signed [prf_pkg::MUL_W-1:0]  mul_a, mul_b;

  logic        keep_r, load_res, res_keep, removed, outside_hit;
  logic [2:0]  rby_r;
  logic [31:0] rcnt_r;

  logic in_acc, out_acc, fs_ok;
  logic [FIW-1:0] fidx;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;
  assign fs_ok   = (int'(filter_slot) < NUM_FILTERS);
  assign fidx    = FIW'(filter_slot);

  // filter table memory
  always_comb begin
    mem_raddr = {cur_r, prf_pkg::WORD_W'(step_r + 5'd1)};
    if (state_r == prf_pkg::ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_r;
      mem_wdata = '0;
    end else begin
      mem_we    = in_acc && kind && fs_ok;
      mem_waddr = {fidx, word_slot};
      mem_wdata = word_value;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tbl_mem[mem_waddr] <= mem_wdata;
    end
    rd_r <= tbl_mem[mem_raddr];
  end

  // counter memory, entries not valid read as zero
  always_comb begin
    cur_cnt = cnt_vld_r[cur_r] ? cnt_rd_r : '0;
    cnt_new = (cur_cnt == {COUNT_WIDTH{1'b1}}) ? cur_cnt : cur_cnt + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (load_res && !res_keep) begin
      cnt_mem[cur_r] <= cnt_new;
    end
    cnt_rd_r <= cnt_mem[cur_r];
  end

  prf_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  // multiplier operands by step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == prf_pkg::ST_EVAL) begin
      priority if (step_r >= 5'd1 && step_r <= prf_pkg::STEP_ROT_LAST) begin
        mul_a = {rd_r[31], rd_r[31:0]};
        if (step_r == 5'd1 || step_r == 5'd4 || step_r == 5'd7) begin
          mul_b = {px_r[31], px_r};
        end else if (step_r == 5'd2 || step_r == 5'd5 || step_r == 5'd8) begin
          mul_b = {py_r[31], py_r};
        end else begin
          mul_b = {pz_r[31], pz_r};
        end
      end else if (step_r == prf_pkg::STEP_SQ0) begin
        mul_a = {v_r[0][31], v_r[0]};
        mul_b = {v_r[0][31], v_r[0]};
      end else if (step_r == prf_pkg::STEP_SQ1) begin
        mul_a = {v_r[1][31], v_r[1]};
        mul_b = {v_r[1][31], v_r[1]};
      end else if (step_r == prf_pkg::STEP_SQ2) begin
        mul_a = {v_r[2][31], v_r[2]};
        mul_b = {v_r[2][31], v_r[2]};
      end else if (step_r == prf_pkg::STEP_CONE_LO) begin
        mul_a = {1'b0, sq_r[0][31:0]};
        mul_b = {thr_r[1][31], thr_r[1][31:0]};
      end else if (step_r == prf_pkg::STEP_CONE_HI) begin
        mul_a = {1'b0, sq_r[0][63:32]};
        mul_b = {thr_r[1][31], thr_r[1][31:0]};
      end else begin
        mul_a = '0;
        mul_b = '0;
      end
    end
  end

  // row sums: first product of a row starts the accumulator
  always_comb begin
    if (step_r == 5'd2 || step_r == 5'd5 || step_r == 5'd8) begin
      sum_cur = prod_r;
    end else begin
      sum_cur = acc_r + prod_r;
    end
  end

  // translation and saturation
  logic signed [prf_pkg::ROW_W:0] tsum;
  logic signed [31:0]             vsat;
  logic [1:0]                     trow;

  always_comb begin
    trow = 2'(step_r - prf_pkg::STEP_TRANS0);
    tsum = {rows_r[trow][prf_pkg::ROW_W-1], rows_r[trow]}
         + {{(prf_pkg::ROW_W - 31){rd_r[31]}}, rd_r[31:0]};
    priority if (tsum > (prf_pkg::ROW_W+1)'(64'sd2147483647)) begin
      vsat = 32'sh7fffffff;
    end else if (tsum < -(prf_pkg::ROW_W+1)'(64'sd2147483648)) begin
      vsat = 32'sh80000000;
    end else begin
      vsat = tsum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == prf_pkg::ST_EVAL) begin
      if (step_r >= 5'd2 && step_r <= prf_pkg::STEP_TRANS0) begin
        acc_r <= sum_cur;
      end
      if (step_r == 5'd4) begin
        rows_r[0] <= sum_cur[prf_pkg::PROD_W-1:28];
      end
      if (step_r == 5'd7) begin
        rows_r[1] <= sum_cur[prf_pkg::PROD_W-1:28];
      end
      if (step_r == prf_pkg::STEP_TRANS0) begin
        rows_r[2] <= sum_cur[prf_pkg::PROD_W-1:28];
      end
      if (step_r >= prf_pkg::STEP_TRANS0 && step_r <= prf_pkg::STEP_TRANS2) begin
        v_r[trow] <= vsat;
      end
      if (step_r >= prf_pkg::STEP_THR0 && step_r <= prf_pkg::STEP_THR2) begin
        thr_r[2'(step_r - prf_pkg::STEP_THR0)] <= rd_r;
      end
      if (step_r == prf_pkg::STEP_SQ1) begin
        sq_r[0] <= prod_r[63:0];
      end
      if (step_r == prf_pkg::STEP_SQ2) begin
        sq_r[1] <= prod_r[63:0];
      end
      if (step_r == prf_pkg::STEP_CONE_LO) begin
        sq_r[2] <= prod_r[63:0];
      end
      if (step_r == prf_pkg::STEP_CONE_HI) begin
        pplo_r <= prod_r[63:0];
      end
      if (step_r == prf_pkg::STEP_CONE_SUM) begin
        cone_r <= {32'b0, pplo_r} + {prod_r[63:0], 32'b0};
      end
    end
  end

  // shape tests
  function automatic logic over_lin(input logic signed [31:0] v, input logic [63:0] w);
    logic signed [33:0] av;
    logic signed [33:0] lim;
    av  = v[31] ? -{{2{v[31]}}, v} : {{2{v[31]}}, v};
    lim = {{2{w[31]}}, w[31:0]};
    return av > lim;
  endfunction

  function automatic logic over_sq(input logic [63:0] sq, input logic [63:0] w);
    return w[63] || (sq > w);
  endfunction

  logic [63:0] sum_yz, sum_xyz;
  logic [2:0]  cur_type;
  logic        cur_inv;

  always_comb begin
    cur_type = typ_r[cur_r][2:0];
    cur_inv  = typ_r[cur_r][3];
    sum_yz   = sq_r[1] + sq_r[2];
    sum_xyz  = sum_yz + sq_r[0];
    unique case (cur_type)
      prf_pkg::TYPE_CUBE: begin
        outside_hit = over_lin(v_r[0], thr_r[0]) || over_lin(v_r[1], thr_r[0])
                   || over_lin(v_r[2], thr_r[0]);
      end
      prf_pkg::TYPE_BLOCK: begin
        outside_hit = over_lin(v_r[0], thr_r[0]) || over_lin(v_r[1], thr_r[1])
                   || over_lin(v_r[2], thr_r[2]);
      end
      prf_pkg::TYPE_SPHERE: begin
        outside_hit = over_sq(sum_xyz, thr_r[0]);
      end
      prf_pkg::TYPE_CYLINDER: begin
        outside_hit = over_sq(sum_yz, thr_r[0]) || over_lin(v_r[0], thr_r[1]);
      end
      prf_pkg::TYPE_CONE: begin
        outside_hit = (v_r[0] <= 32'sd0) || (v_r[0] > $signed(thr_r[0][31:0]))
                   || thr_r[1][31] || ({16'b0, sum_yz, 16'b0} > cone_r);
      end
      default: begin
        outside_hit = 1'b0;
      end
    endcase
    removed = !(outside_hit ^ cur_inv);
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    step_nxt  = step_r;
    in_tready = 1'b0;
    out_tvalid = 1'b0;
    load_res  = 1'b0;
    res_keep  = 1'b1;
    unique case (state_r)
      prf_pkg::ST_CLEAR: begin
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = prf_pkg::ST_IDLE;
        end
      end
      prf_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid && !kind) begin
          state_nxt = prf_pkg::ST_SCAN;
          cur_nxt   = FIW'(NUM_FILTERS - 1);
        end
      end
      prf_pkg::ST_SCAN: begin
        if (typ_r[cur_r][2:0] != prf_pkg::TYPE_NONE) begin
          state_nxt = prf_pkg::ST_EVAL;
          step_nxt  = '0;
        end else if (cur_r == '0) begin
          load_res  = 1'b1;
          state_nxt = prf_pkg::ST_OUT;
        end else begin
          cur_nxt = cur_r - 1'b1;
        end
      end
      prf_pkg::ST_EVAL: begin
        step_nxt = step_r + 5'd1;
        if (step_r == prf_pkg::STEP_DECIDE) begin
          if (removed) begin
            load_res  = 1'b1;
            res_keep  = 1'b0;
            state_nxt = prf_pkg::ST_OUT;
          end else if (cur_r == '0) begin
            load_res  = 1'b1;
            state_nxt = prf_pkg::ST_OUT;
          end else begin
            cur_nxt   = cur_r - 1'b1;
            state_nxt = prf_pkg::ST_SCAN;
          end
        end
      end
      prf_pkg::ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          state_nxt = prf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = prf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= prf_pkg::ST_CLEAR;
      cur_r     <= '0;
      step_r    <= '0;
      clr_r     <= '0;
      cnt_vld_r <= '0;
      for (int i = 0; i < NUM_FILTERS; i++) begin
        typ_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      step_r  <= step_nxt;
      if (state_r == prf_pkg::ST_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (in_acc && kind && fs_ok && word_slot == prf_pkg::WORD_TYPE) begin
        typ_r[fidx] <= word_value[3:0];
      end
      if (in_acc && !kind && first_point) begin
        cnt_vld_r <= '0;
      end else if (load_res && !res_keep) begin
        cnt_vld_r[cur_r] <= 1'b1;
      end
    end
  end

  // point latch and result register
  always_ff @(posedge clk) begin
    if (in_acc && !kind) begin
      px_r <= coord_x;
      py_r <= coord_y;
      pz_r <= coord_z;
    end
    if (load_res) begin
      keep_r <= res_keep;
      rby_r  <= res_keep ? 3'd0 : 3'(cur_r);
      rcnt_r <= res_keep ? 32'd0 : 32'(cnt_new);
    end
  end

  assign out_tdata = {5'b0, rcnt_r, rby_r};
  assign out_tuser = keep_r;

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input and result side active together");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == prf_pkg::ST_EVAL |-> step_r <= prf_pkg::STEP_DECIDE)
    else $error("evaluation step out of schedule");

  a_keep_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && keep_r |-> rby_r == 3'd0 && rcnt_r == 32'd0)
    else $error("kept point carries removal data");

  a_point_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !kind |=> state_r == prf_pkg::ST_SCAN)
    else $error("point request did not start a scan");

endmodule

@@ hdl/prf_mul.sv @@
// shared registered 33x33 signed multiplier
`timescale 1ns / 1ps

module prf_mul (
  input  logic                                 clk,
  input  logic signed [prf_pkg::MUL_W-1:0]     mul_a,
  input  logic signed [prf_pkg::MUL_W-1:0]     mul_b,
  output logic signed [prf_pkg::PROD_W-1:0]    prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

endmodule

@@ dv/point_region_filter_tb.sv @@
// self-checking testbench of the point region filter
`timescale 1ns / 1ps

module point_region_filter_tb;

  localparam int NFILT = 8;
  localparam int ITEMS = 1350;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam logic [2:0] TYPE_RSVD6 = 3'd6;
  localparam logic [2:0] TYPE_RSVD7 = 3'd7;
  localparam int WORD_ROT0 = 1;
  localparam int WORD_TRANS0 = 10;
  localparam int WORD_THR0 = 13;
  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
  localparam logic [31:0] ONE_Q28 = 32'h1000_0000;

  typedef struct packed {
    logic        keep;
    logic [2:0]  removed_by;
    logic [31:0] removal_count;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [prf_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic [prf_pkg::IN_TUSER_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [prf_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [prf_pkg::OUT_TUSER_W-1:0] out_tuser;

  logic [63:0] region_words [NFILT*prf_pkg::WORDS_PER_FILTER];
  logic [31:0] drop_counts [NFILT];
  verdict_t    pending_verdicts [$];
  int          fail_count = 0;
  int          items_sent = 0;
  longint      cycle_count = 0;
  bit          burst_mode = 1'b0;

  point_region_filter #(.NUM_FILTERS(NFILT), .COUNT_WIDTH(32)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // v = R*p + t, floored to Q16.16 and saturated
  function automatic longint transform_row(int f, int i, logic [31:0] px, logic [31:0] py,
                                           logic [31:0] pz);
    logic signed [69:0] acc;
    logic signed [69:0] a;
    logic signed [69:0] b;
    logic [31:0] pv [3];
    pv[0] = px; pv[1] = py; pv[2] = pz;
    acc = '0;
    for (int j = 0; j < 3; j++) begin
      a = $signed(region_words[f*16 + WORD_ROT0 + i*3 + j][31:0]);
      b = $signed(pv[j]);
      acc += a * b;
    end
    acc = (acc >>> 28);
    a = $signed(region_words[f*16 + WORD_TRANS0 + i][31:0]);
    acc += a;
    if (acc > 70'sd2147483647) return 64'sd2147483647;
    if (acc < -70'sd2147483648) return -64'sd2147483648;
    return longint'(acc);
  endfunction

  function automatic bit over_lin(longint v, logic [63:0] w);
    longint lim;
    lim = longint'($signed(w[31:0]));
    return ((v < 0) ? -v : v) > lim;
  endfunction

  function automatic bit over_sq(logic [63:0] s, logic [63:0] w);
    if (w[63]) return 1'b1;
    return s > w;
  endfunction

  function automatic bit lies_outside(int f, longint v0, longint v1, longint v2);
    logic [63:0] s0, s1, s2, w0, w1, w2;
    logic [127:0] lhs, rhs;
    s0 = v0 * v0; s1 = v1 * v1; s2 = v2 * v2;
    w0 = region_words[f*16 + WORD_THR0];
    w1 = region_words[f*16 + WORD_THR0 + 1];
    w2 = region_words[f*16 + WORD_THR0 + 2];
    case (region_words[f*16 + prf_pkg::WORD_TYPE][2:0])
      prf_pkg::TYPE_CUBE:
        return over_lin(v0, w0) || over_lin(v1, w0) || over_lin(v2, w0);
      prf_pkg::TYPE_BLOCK:
        return over_lin(v0, w0) || over_lin(v1, w1) || over_lin(v2, w2);
      prf_pkg::TYPE_SPHERE: return over_sq(s0 + s1 + s2, w0);
      prf_pkg::TYPE_CYLINDER: return over_sq(s1 + s2, w0) || over_lin(v0, w1);
      prf_pkg::TYPE_CONE: begin
        if (v0 <= 0) return 1'b1;
        if (v0 > longint'($signed(w0[31:0]))) return 1'b1;
        if (w1[31]) return 1'b1;
        lhs = {64'b0, s1 + s2} << 16;
        rhs = {64'b0, s0} * {96'b0, w1[31:0]};
        return lhs > rhs;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic verdict_t classify_point(logic [31:0] px, logic [31:0] py,
                                              logic [31:0] pz, logic clear);
    verdict_t r;
    bit hit;
    longint v0, v1, v2;
    if (clear) foreach (drop_counts[k]) drop_counts[k] = '0;
    for (int f = NFILT - 1; f >= 0; f--) begin
      if (region_words[f*16 + prf_pkg::WORD_TYPE][2:0] == prf_pkg::TYPE_NONE) continue;
      v0 = transform_row(f, 0, px, py, pz);
      v1 = transform_row(f, 1, px, py, pz);
      v2 = transform_row(f, 2, px, py, pz);
      hit = lies_outside(f, v0, v1, v2) ^ region_words[f*16 + prf_pkg::WORD_TYPE][3];
      if (!hit) begin
        if (drop_counts[f] != 32'hFFFF_FFFF) drop_counts[f]++;
        r.keep = 1'b0;
        r.removed_by = 3'(f);
        r.removal_count = drop_counts[f];
        return r;
      end
    end
    r.keep = 1'b1;
    r.removed_by = '0;
    r.removal_count = '0;
    return r;
  endfunction

  task automatic send_request(logic kind, logic first, logic [31:0] px, logic [31:0] py,
                              logic [31:0] pz, logic [2:0] fslot, logic [3:0] wslot,
                              logic [63:0] wval);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata = {1'b0, wval, wslot, fslot, pz, py, px};
    in_tuser = {first, kind};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    if (kind) region_words[fslot*16 + wslot] = wval;
    else pending_verdicts.push_back(classify_point(px, py, pz, first));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_word(int f, int w, logic [63:0] val);
    send_request(1'b1, $urandom_range(0, 1), $urandom, $urandom, $urandom, 3'(f), 4'(w), val);
  endtask

  task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz, logic first);
    send_request(1'b0, first, px, py, pz, 3'($urandom), 4'($urandom), {$urandom, $urandom});
  endtask

  // axis-aligned filter: identity rotation scaled by diag
  task automatic load_simple(int f, logic [2:0] kind, logic inv, logic [31:0] diag,
                             logic [63:0] t0, logic [63:0] t1, logic [63:0] t2);
    write_word(f, prf_pkg::WORD_TYPE, {60'b0, inv, kind});
    for (int k = 0; k < 9; k++) write_word(f, WORD_ROT0 + k, (k % 4 == 0) ? {32'b0, diag} : 64'b0);
    for (int k = 0; k < 3; k++) write_word(f, WORD_TRANS0 + k, 64'b0);
    write_word(f, WORD_THR0, t0);
    write_word(f, WORD_THR0 + 1, t1);
    write_word(f, WORD_THR0 + 2, t2);
  endtask

  function automatic logic [31:0] near_coord();
    return 32'($urandom_range(0, 20 * 65536)) - 32'(10 * 65536);
  endfunction

  function automatic logic [31:0] lin_limit();
    if ($urandom_range(0, 11) == 0) return -32'($urandom_range(1, 65536));
    return 32'($urandom_range(0, 8 * 65536));
  endfunction

  task automatic load_random(int f);
    logic [2:0] kind;
    bit wild;
    kind = 3'($urandom_range(0, 7));
    wild = ($urandom_range(0, 9) == 0);
    write_word(f, prf_pkg::WORD_TYPE, {$urandom, 28'($urandom), 1'($urandom), kind});
    for (int k = 0; k < 9; k++) begin
      if (wild) write_word(f, WORD_ROT0 + k, {$urandom, $urandom});
      else if (k % 4 == 0)
        write_word(f, WORD_ROT0 + k, {$urandom, 32'($urandom_range(0, 2*ONE_Q28)) - ONE_Q28});
      else write_word(f, WORD_ROT0 + k, {$urandom, 32'($urandom_range(0, 1 << 27)) - (1 << 26)});
    end
    for (int k = 0; k < 3; k++)
      write_word(f, WORD_TRANS0 + k, {$urandom, 32'($urandom_range(0, 8 << 16)) - (4 << 16)});
    if (kind == prf_pkg::TYPE_SPHERE || kind == prf_pkg::TYPE_CYLINDER)
      write_word(f, WORD_THR0, ($urandom_range(0, 11) == 0) ? {1'b1, 63'($urandom)} :
                 {32'($urandom_range(0, 80)), $urandom});
    else write_word(f, WORD_THR0, {$urandom, lin_limit()});
    if (kind == prf_pkg::TYPE_CONE)
      write_word(f, WORD_THR0 + 1, {$urandom, ($urandom_range(0, 11) == 0) ?
                 -32'd5 : 32'($urandom_range(0, 4 << 16))});
    else write_word(f, WORD_THR0 + 1, {$urandom, lin_limit()});
    write_word(f, WORD_THR0 + 2, {$urandom, lin_limit()});
  endtask

  task automatic test_empty_table();
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b1);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_point(32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF, 1'b0);
  endtask

  task automatic test_each_shape();
    logic [2:0] kinds [7];
    kinds = '{prf_pkg::TYPE_CUBE, prf_pkg::TYPE_BLOCK, prf_pkg::TYPE_SPHERE,
              prf_pkg::TYPE_CYLINDER, prf_pkg::TYPE_CONE, TYPE_RSVD6, TYPE_RSVD7};
    foreach (kinds[k]) begin
      load_simple(0, kinds[k], k == 2, ONE_Q28, {32'b0, ONE_Q16 * 2},
                  {32'b0, ONE_Q16}, {32'b0, ONE_Q16 * 3});
      send_point(ONE_Q16 / 2, ONE_Q16 / 4, 32'h0, 1'b0);
      send_point(ONE_Q16 * 5, -ONE_Q16, ONE_Q16, 1'b0);
    end
    // cone apex side and a negative threshold
    load_simple(1, prf_pkg::TYPE_CONE, 1'b0, ONE_Q28, {32'b0, ONE_Q16 * 4},
                {32'b0, ONE_Q16}, 64'b0);
    send_point(-ONE_Q16, 32'h0, 32'h0, 1'b0);
    send_point(ONE_Q16, ONE_Q16 / 2, ONE_Q16 / 2, 1'b0);
    load_simple(1, prf_pkg::TYPE_CUBE, 1'b0, ONE_Q28, {32'b0, -ONE_Q16}, 64'b0, 64'b0);
    send_point(32'h0, 32'h0, 32'h0, 1'b0);
    // transform saturation both ways
    load_simple(2, prf_pkg::TYPE_BLOCK, 1'b0, 32'h7FFF_FFFF, 64'h7FFF_FFFF, 64'h7FFF_FFFF,
                64'h7FFF_FFFF);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b1);
    for (int f = 0; f < 3; f++) write_word(f, prf_pkg::WORD_TYPE, 64'b0);
  endtask

  task automatic test_random_stream();
    int pick;
    while (items_sent < ITEMS) begin
      if ($urandom_range(0, 99) == 0) burst_mode = ~burst_mode;
      pick = $urandom_range(0, 59);
      if (pick < 3) load_random($urandom_range(0, NFILT - 1));
      else if (pick < 5)
        write_word($urandom_range(0, NFILT - 1), $urandom_range(0, 15), {$urandom, $urandom});
      else if (pick < 10) send_point($urandom, $urandom, $urandom, $urandom_range(0, 7) == 0);
      else send_point(near_coord(), near_coord(), near_coord(), $urandom_range(0, 29) == 0);
    end
    in_tvalid = 1'b0;
    burst_mode = 1'b0;
  endtask

  // receiver with random backpressure
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      out_tready = 1'b0;
      repeat ((burst_mode || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13))
        @(negedge clk);
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_verdicts.size() == 0) begin
        $error("unexpected result: keep %0d removed_by %0d", out_tuser[0], out_tdata[2:0]);
        fail_count++;
      end else begin
        verdict_t want;
        want = pending_verdicts.pop_front();
        if (out_tuser[0] !== want.keep) begin
          $error("keep: expected %0d, got %0d", want.keep, out_tuser[0]);
          fail_count++;
        end
        if (out_tdata[2:0] !== want.removed_by) begin
          $error("removed_by: expected %0d, got %0d", want.removed_by, out_tdata[2:0]);
          fail_count++;
        end
        if (out_tdata[34:3] !== want.removal_count) begin
          $error("removal_count: expected %0d, got %0d", want.removal_count, out_tdata[34:3]);
          fail_count++;
        end
      end
    end
  end

  initial begin
    foreach (region_words[k]) region_words[k] = '0;
    foreach (drop_counts[k]) drop_counts[k] = '0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    test_empty_table();
    test_each_shape();
    test_random_stream();
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0 && pending_verdicts.size() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
